### design/ect_pkg.sv
// ect_pkg: shared types, codes and defaults for the exon coordinate translator
// depends on: nothing
package ect_pkg;

   // default sizing
   localparam int MAX_EXONS_DEF  = 64;
   localparam int COORD_BITS_DEF = 32;

   // item kinds
   localparam logic [1:0] KIND_EXON   = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_STOP   = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   // latched error codes (same values as the matching status codes)
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_UNORDERED = 2'd1;
   localparam logic [1:0] ERR_DUPLICATE = 2'd2;
   localparam logic [1:0] ERR_FULL      = 2'd3;

   // result status codes
   localparam logic [3:0] STS_OK       = 4'd0;
   localparam logic [3:0] STS_NO_START = 4'd4;
   localparam logic [3:0] STS_NO_STOP  = 4'd5;
   localparam logic [3:0] STS_ORDER    = 4'd6;
   localparam logic [3:0] STS_NO_EXONS = 4'd7;
   localparam logic [3:0] STS_OVERLAP  = 4'd8;
   localparam logic [3:0] STS_OUTSIDE  = 4'd9;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_WALK,
      ST_FIN,
      ST_EMIT
   } state_type;

   // walk unit control and status
   typedef struct packed {
      logic clear;
      logic step;
   } walk_ctl_type;

   typedef struct packed {
      logic overlap;
      logic done;
      logic ok;
   } walk_sts_type;

endpackage

### design/ect_channels.sv
// ect_channels: valid/ready channel interfaces for request, response and csr write
// depends on: nothing
interface ect_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] pos_from;
   logic [31:0] pos_to;

   modport source (output valid, output kind, output pos_from, output pos_to, input ready);
   modport sink   (input valid, input kind, input pos_from, input pos_to, output ready);
endinterface

interface ect_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] cds_start;
   logic [31:0] cds_stop;
   logic        found;
   logic [3:0]  status;

   modport source (output valid, output cds_start, output cds_stop, output found,
                   output status, input ready);
   modport sink   (input valid, input cds_start, input cds_stop, input found,
                   input status, output ready);
endinterface

interface ect_csr_if;
   logic valid;
   logic ready;
   logic plus_strand;

   modport source (output valid, output plus_strand, input ready);
   modport sink   (input valid, input plus_strand, output ready);
endinterface

### design/ect_table_ram.sv
// ect_table_ram: simple dual-port exon table, one write and one registered read port
// depends on: nothing
module ect_table_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ect_walk_unit.sv
// ect_walk_unit: one exon per step, overlap check and transcript position sums
// depends on: ect_pkg
module ect_walk_unit
   import ect_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  walk_ctl_type          ctl,
   input  logic [COORD_BITS-1:0] entry_first,
   input  logic [COORD_BITS-1:0] entry_last,
   input  logic [COORD_BITS-1:0] start_key,
   input  logic [COORD_BITS-1:0] stop_key,
   output walk_sts_type          sts,
   output logic [COORD_BITS-1:0] spos,
   output logic [COORD_BITS-1:0] tpos
);

   localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

   logic [COORD_BITS-1:0] prev_ff, prev_in;
   logic [COORD_BITS-1:0] spos_ff, spos_in;
   logic [COORD_BITS-1:0] tpos_ff, tpos_in;
   logic                  phase_ff, phase_in;
   logic                  done_ff, done_in;
   logic                  ok_ff, ok_in;
   logic                  ovl_ff, ovl_in;

   logic [COORD_BITS-1:0] exon_len;
   logic [COORD_BITS-1:0] start_off;
   logic [COORD_BITS-1:0] stop_off;

   // offsets inside the current exon
   assign exon_len  = entry_last - entry_first + ONE;
   assign start_off = start_key - entry_first + ONE;
   assign stop_off  = stop_key - entry_first + ONE;

   // step logic
   always_comb begin
      prev_in  = prev_ff;
      spos_in  = spos_ff;
      tpos_in  = tpos_ff;
      phase_in = phase_ff;
      done_in  = done_ff;
      ok_in    = ok_ff;
      ovl_in   = ovl_ff;
      if (ctl.clear) begin
         prev_in  = '0;
         spos_in  = '0;
         tpos_in  = '0;
         phase_in = 1'b0;
         done_in  = 1'b0;
         ok_in    = 1'b0;
         ovl_in   = 1'b0;
      end else if (ctl.step) begin
         // an exon first key of zero also trips this, previous end starts at zero
         if (prev_ff >= entry_first) begin
            ovl_in = 1'b1;
         end
         prev_in = entry_last;
         if (!done_ff) begin
            if (!phase_ff) begin
               // looking for the start codon
               if (start_key < entry_first) begin
                  done_in = 1'b1;
               end else if (start_key <= entry_last) begin
                  spos_in = spos_ff + start_off;
                  if (stop_key <= entry_last) begin
                     tpos_in = spos_ff + stop_off;
                     done_in = 1'b1;
                     ok_in   = 1'b1;
                  end else begin
                     tpos_in  = spos_ff + exon_len;
                     phase_in = 1'b1;
                  end
               end else begin
                  spos_in = spos_ff + exon_len;
               end
            end else begin
               // looking for the stop codon
               if (stop_key < entry_first) begin
                  done_in = 1'b1;
               end else if (stop_key <= entry_last) begin
                  tpos_in = tpos_ff + stop_off;
                  done_in = 1'b1;
                  ok_in   = 1'b1;
               end else begin
                  tpos_in = tpos_ff + exon_len;
               end
            end
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
         ok_ff    <= 1'b0;
         ovl_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         ok_ff    <= ok_in;
         ovl_ff   <= ovl_in;
      end
   end

   // running sums
   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      spos_ff <= spos_in;
      tpos_ff <= tpos_in;
   end

   assign sts.overlap = ovl_ff;
   assign sts.done    = done_ff;
   assign sts.ok      = ok_ff;
   assign spos        = spos_ff;
   assign tpos        = tpos_ff;

endmodule

### design/exon_coordinate_translator_unit.sv
// exon codon coordinate translator: sorted exon table in memory, finish walk emits result
// items: codon and unordered exon beats stay in ST_IDLE; other exons shift larger entries in ST_SCAN or go to ST_PLACE
// finish: an early check goes through ST_EMIT to the result register, else ST_WALK over each exon, ST_FIN, ST_EMIT
// throughput: one item at a time, bounded by the table walk through the single read port
// reset: synchronous; clears count, codon keys, error latch, strand to plus; table kept
// depends on: ect_pkg, ect_channels, ect_table_ram, ect_walk_unit
module exon_coordinate_translator_unit
   import ect_pkg::*;
#(
   parameter int MAX_EXONS  = MAX_EXONS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   ect_req_if.sink   req_bus,
   ect_rsp_if.source rsp_bus,
   ect_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(MAX_EXONS);
   localparam int CW = $clog2(MAX_EXONS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXONS);
   localparam logic [CW-1:0] CNT_ONE = {{(CW-1){1'b0}}, 1'b1};
   localparam logic [CW-1:0] CNT_TWO = CW'(2);

   state_type state_ff, state_in;

   logic                    plus_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           ptr_ff, ptr_in;
   logic [CW-1:0]           rd_idx_ff, rd_idx_in;
   logic [COORD_BITS-1:0]   start_ff, start_in;
   logic [COORD_BITS-1:0]   stop_ff, stop_in;
   logic [1:0]              err_ff, err_in;
   logic [COORD_BITS-1:0]   kfirst_ff, kfirst_in;
   logic [COORD_BITS-1:0]   klast_ff, klast_in;
   logic [3:0]              pend_ff, pend_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_start_ff, rsp_start_in;
   logic [31:0]             rsp_stop_ff, rsp_stop_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [3:0]              rsp_status_ff, rsp_status_in;

   // input reduction and key forming
   logic [COORD_BITS+31:0]  a_ext, b_ext;
   logic [COORD_BITS-1:0]   a_red, b_red;
   logic [COORD_BITS-1:0]   key_first, key_last;

   // memory ports
   logic                    wr_en, rd_en;
   logic [CW-1:0]           wr_addr, rd_addr;
   logic [2*COORD_BITS-1:0] wr_data, rd_data;
   logic [COORD_BITS-1:0]   rd_first, rd_last;

   // walk unit
   walk_ctl_type            wctl;
   walk_sts_type            wsts;
   logic [COORD_BITS-1:0]   spos, tpos;
   logic [COORD_BITS+31:0]  spos_ext, tpos_ext;

   logic                    full;
   logic                    emit_go;

   assign a_ext     = {{COORD_BITS{1'b0}}, req_bus.pos_from};
   assign b_ext     = {{COORD_BITS{1'b0}}, req_bus.pos_to};
   assign a_red     = a_ext[COORD_BITS-1:0];
   assign b_red     = b_ext[COORD_BITS-1:0];
   assign key_first = plus_ff ? a_red : ('0 - b_red);
   assign key_last  = plus_ff ? b_red : ('0 - a_red);

   assign rd_first  = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign rd_last   = rd_data[COORD_BITS-1:0];
   assign full      = (count_ff == MAX_CNT);
   assign emit_go   = !rsp_valid_ff || rsp_bus.ready;

   assign spos_ext  = {32'b0, spos};
   assign tpos_ext  = {32'b0, tpos};

   // exon table
   ect_table_ram #(
      .DEPTH (MAX_EXONS),
      .WIDTH (2 * COORD_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (rd_data)
   );

   // finish walk
   ect_walk_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .ctl         (wctl),
      .entry_first (rd_first),
      .entry_last  (rd_last),
      .start_key   (start_ff),
      .stop_key    (stop_ff),
      .sts         (wsts),
      .spos        (spos),
      .tpos        (tpos)
   );

   // strand register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_ff <= 1'b1;
      end else if (csr_bus.valid) begin
         plus_ff <= csr_bus.plus_strand;
      end
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      rd_idx_in     = rd_idx_ff;
      start_in      = start_ff;
      stop_in       = stop_ff;
      err_in        = err_ff;
      kfirst_in     = kfirst_ff;
      klast_in      = klast_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_start_in  = rsp_start_ff;
      rsp_stop_in   = rsp_stop_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = {kfirst_ff, klast_ff};
      rd_en         = 1'b0;
      rd_addr       = '0;
      wctl          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               case (req_bus.kind)
                  KIND_EXON: begin
                     // exons after an error cannot change the result
                     if (err_ff == ERR_NONE) begin
                        if (a_red > b_red) begin
                           err_in = ERR_UNORDERED;
                        end else begin
                           kfirst_in = key_first;
                           klast_in  = key_last;
                           if (count_ff == '0) begin
                              ptr_in   = '0;
                              state_in = ST_PLACE;
                           end else begin
                              rd_en    = 1'b1;
                              rd_addr  = count_ff - CNT_ONE;
                              ptr_in   = count_ff;
                              state_in = ST_SCAN;
                           end
                        end
                     end
                  end
                  KIND_START: begin
                     if (start_ff == '0 || key_first < start_ff) begin
                        start_in = key_first;
                     end
                  end
                  KIND_STOP: begin
                     if (stop_ff == '0 || key_first < stop_ff) begin
                        stop_in = key_first;
                     end
                  end
                  default: begin
                     // finish: early checks in code order
                     state_in = ST_EMIT;
                     if (err_ff != ERR_NONE) begin
                        pend_in = {2'b00, err_ff};
                     end else if (start_ff == '0) begin
                        pend_in = STS_NO_START;
                     end else if (stop_ff == '0) begin
                        pend_in = STS_NO_STOP;
                     end else if (start_ff > stop_ff) begin
                        pend_in = STS_ORDER;
                     end else if (count_ff == '0) begin
                        pend_in = STS_NO_EXONS;
                     end else begin
                        wctl.clear = 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        rd_idx_in  = CNT_ONE;
                        state_in   = ST_WALK;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // rd_data holds entry ptr-1; larger keys move up one slot
            if (rd_first > kfirst_ff) begin
               if (!full) begin
                  wr_en   = 1'b1;
                  wr_addr = ptr_ff;
                  wr_data = rd_data;
               end
               ptr_in = ptr_ff - CNT_ONE;
               if (ptr_ff == CNT_ONE) begin
                  if (full) begin
                     err_in   = ERR_FULL;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_PLACE;
                  end
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff - CNT_TWO;
               end
            end else begin
               state_in = ST_IDLE;
               if (rd_first == kfirst_ff) begin
                  err_in = ERR_DUPLICATE;
               end else if (full) begin
                  err_in = ERR_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = ptr_ff;
                  count_in = count_ff + CNT_ONE;
               end
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            count_in = count_ff + CNT_ONE;
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            // one exon per cycle, reads run one entry ahead
            wctl.step = 1'b1;
            if (rd_idx_ff == count_ff) begin
               state_in = ST_FIN;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = rd_idx_ff;
               rd_idx_in = rd_idx_ff + CNT_ONE;
            end
         end
         ST_FIN: begin
            if (wsts.overlap) begin
               pend_in = STS_OVERLAP;
            end else if (wsts.done && wsts.ok) begin
               pend_in = STS_OK;
            end else begin
               pend_in = STS_OUTSIDE;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_ff;
               rsp_found_in  = (pend_ff == STS_OK);
               rsp_start_in  = (pend_ff == STS_OK) ? spos_ext[31:0] : 32'b0;
               rsp_stop_in   = (pend_ff == STS_OK) ? tpos_ext[31:0] : 32'b0;
               count_in      = '0;
               start_in      = '0;
               stop_in       = '0;
               err_in        = ERR_NONE;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         start_ff     <= '0;
         stop_ff      <= '0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         stop_ff      <= stop_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      rd_idx_ff     <= rd_idx_in;
      kfirst_ff     <= kfirst_in;
      klast_ff      <= klast_in;
      pend_ff       <= pend_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_stop_ff   <= rsp_stop_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.cds_start = rsp_start_ff;
   assign rsp_bus.cds_stop  = rsp_stop_ff;
   assign rsp_bus.found     = rsp_found_ff;
   assign rsp_bus.status    = rsp_status_ff;

`ifndef SYNTH
   // a delivered result leaves the transcript state cleared
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && emit_go) |=> (count_ff == '0 && err_ff == ERR_NONE
         && start_ff == '0 && stop_ff == '0))
      else $error("transcript state not cleared after result");

   // found flag agrees with an ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_found_ff == (rsp_status_ff == STS_OK)))
      else $error("found flag disagrees with status");

   // the table is never written while it is being walked
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK || state_ff == ST_FIN) |-> !wr_en)
      else $error("table write during finish walk");

   // writes stay inside the table
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr < MAX_CNT && count_ff < MAX_CNT))
      else $error("table write beyond depth");
`endif

endmodule

### dv/exon_coordinate_translator_unit_tb.sv
`timescale 1ns / 100ps
// exon_coordinate_translator_unit_tb: self-checking bench, transcripts of exon and codon beats
// depends on: ect_pkg, ect_channels, exon_coordinate_translator_unit
module exon_coordinate_translator_unit_tb
   import ect_pkg::*;
();

   localparam int ITEM_GOAL   = 600;
   localparam int TAIL_CYCLES = MAX_EXONS_DEF + 16;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      bit [1:0]  kind;
      bit [31:0] pos_from;
      bit [31:0] pos_to;
   } request_type;

   typedef struct {
      bit [31:0] cds_start;
      bit [31:0] cds_stop;
      bit        found;
      bit [3:0]  status;
   } cds_result_type;

   // shapes of broken transcripts
   typedef enum int {
      FAULT_NONE, FAULT_UNORDERED, FAULT_DUPLICATE, FAULT_FULL, FAULT_NO_START, FAULT_NO_STOP,
      FAULT_ORDER, FAULT_NO_EXONS, FAULT_OVERLAP, FAULT_OUTSIDE, FAULT_ZERO_KEY, FAULT_NOISE
   } fault_type;

   // transcript model: sorted exon keys, codon keys, first error; queue of awaited results
   class cds_scoreboard;
      bit             plus_strand = 1'b1;
      bit [31:0]      exon_lo[$];
      bit [31:0]      exon_hi[$];
      bit [31:0]      start_key;
      bit [31:0]      stop_key;
      bit [1:0]       err_code;
      cds_result_type awaited[$];
      int             failures = 0;

      function new();
         clear_transcript();
      endfunction

      function void clear_transcript();
         exon_lo.delete();
         exon_hi.delete();
         start_key = '0;
         stop_key  = '0;
         err_code  = ERR_NONE;
      endfunction

      function void note_error(bit [1:0] code);
         if (err_code == ERR_NONE) err_code = code;
      endfunction

      // checks in code order, then walk the exons summing lengths
      function bit [3:0] place_codons(output bit [31:0] cs, output bit [31:0] ct);
         bit [31:0] prev_end;
         bit [31:0] run_s;
         bit [31:0] run_t;
         cs = '0;
         ct = '0;
         prev_end = '0;
         run_s = '0;
         if (err_code != ERR_NONE) return {2'b00, err_code};
         if (start_key == 0) return STS_NO_START;
         if (stop_key == 0) return STS_NO_STOP;
         if (start_key > stop_key) return STS_ORDER;
         if (exon_lo.size() == 0) return STS_NO_EXONS;
         for (int i = 0; i < exon_lo.size(); i++) begin
            if (prev_end >= exon_lo[i]) return STS_OVERLAP;
            prev_end = exon_hi[i];
         end
         for (int i = 0; i < exon_lo.size(); i++) begin
            if (start_key < exon_lo[i]) return STS_OUTSIDE;
            if (start_key <= exon_hi[i]) begin
               run_t = run_s;
               run_s = run_s + start_key - exon_lo[i] + 1;
               for (int j = i; j < exon_lo.size(); j++) begin
                  if (stop_key < exon_lo[j]) return STS_OUTSIDE;
                  if (stop_key <= exon_hi[j]) begin
                     cs = run_s;
                     ct = run_t + stop_key - exon_lo[j] + 1;
                     return STS_OK;
                  end
                  run_t = run_t + exon_hi[j] - exon_lo[j] + 1;
               end
               return STS_OUTSIDE;
            end
            run_s = run_s + exon_hi[i] - exon_lo[i] + 1;
         end
         return STS_OUTSIDE;
      endfunction

      function void note_request(bit [1:0] kind, bit [31:0] from, bit [31:0] to);
         bit [31:0]      k_lo;
         bit [31:0]      k_hi;
         bit [31:0]      codon;
         int             slot;
         cds_result_type r;
         case (kind)
            KIND_EXON: begin
               if (from > to) begin
                  note_error(ERR_UNORDERED);
               end else begin
                  k_lo = plus_strand ? from : 32'd0 - to;
                  k_hi = plus_strand ? to : 32'd0 - from;
                  slot = 0;
                  while (slot < exon_lo.size() && exon_lo[slot] < k_lo) slot++;
                  if (slot < exon_lo.size() && exon_lo[slot] == k_lo) begin
                     note_error(ERR_DUPLICATE);
                  end else if (exon_lo.size() >= MAX_EXONS_DEF) begin
                     note_error(ERR_FULL);
                  end else begin
                     exon_lo.insert(slot, k_lo);
                     exon_hi.insert(slot, k_hi);
                  end
               end
            end
            KIND_START: begin
               codon = plus_strand ? from : 32'd0 - to;
               if (start_key == 0 || codon < start_key) start_key = codon;
            end
            KIND_STOP: begin
               codon = plus_strand ? from : 32'd0 - to;
               if (stop_key == 0 || codon < stop_key) stop_key = codon;
            end
            default: begin
               r.status = place_codons(r.cds_start, r.cds_stop);
               r.found  = (r.status == STS_OK);
               awaited.push_back(r);
               clear_transcript();
            end
         endcase
      endfunction

      function void check_response(logic [31:0] got_start, logic [31:0] got_stop,
                                   logic got_found, logic [3:0] got_status);
         cds_result_type want;
         if (awaited.size() == 0) begin
            $error("result beat with no finish pending, status %0d", got_status);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got_start !== want.cds_start) begin
            $error("cds_start: expected %0d, got %0d", want.cds_start, got_start);
            failures++;
         end
         if (got_stop !== want.cds_stop) begin
            $error("cds_stop: expected %0d, got %0d", want.cds_stop, got_stop);
            failures++;
         end
         if (got_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got_found);
            failures++;
         end
         if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            failures++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ect_req_if req_bus ();
   ect_rsp_if rsp_bus ();
   ect_csr_if csr_bus ();

   exon_coordinate_translator_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   cds_scoreboard board = new();
   bit        strand_now = 1'b1;
   bit        sender_calm = 1'b0;
   int        items_sent = 0;
   int        results_seen = 0;
   bit [31:0] key_first[$];
   bit [31:0] key_last[$];

   // receiver stall state
   int hold_left = 0;
   int stall_left = 0;
   int calm_left = 0;
   bit pressure_done = 1'b0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic request_type exon_item(bit [31:0] k_lo, bit [31:0] k_hi);
      request_type r;
      r.kind = KIND_EXON;
      r.pos_from = strand_now ? k_lo : 32'd0 - k_hi;
      r.pos_to   = strand_now ? k_hi : 32'd0 - k_lo;
      return r;
   endfunction

   // the field that does not form the key gets a loose value
   function automatic request_type codon_item(bit [1:0] kind, bit [31:0] key);
      request_type r;
      r.kind = kind;
      if (strand_now) begin
         r.pos_from = key;
         r.pos_to   = $urandom_range(0, 1) ? $urandom : key + 2;
      end else begin
         r.pos_to   = 32'd0 - key;
         r.pos_from = $urandom_range(0, 1) ? $urandom : r.pos_to - 2;
      end
      return r;
   endfunction

   // the real fragment plus a few with larger keys that must lose
   function automatic void add_codon_fragments(ref request_type batch[$],
                                               input bit [1:0] kind, input bit [31:0] key);
      longint bumped;
      batch.push_back(codon_item(kind, key));
      repeat ($urandom_range(0, 2)) begin
         bumped = longint'(key) + $urandom_range(1, 50);
         if (bumped <= 64'hFFFF_FFFF) batch.push_back(codon_item(kind, bumped[31:0]));
      end
   endfunction

   function automatic bit [31:0] wild_coord();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(1, 400);
         default: return $urandom;
      endcase
   endfunction

   // one request beat, called and left at a falling edge
   task automatic push_request(input bit [1:0] kind, input bit [31:0] from, input bit [31:0] to);
      int gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= kind;
      req_bus.pos_from <= from;
      req_bus.pos_to   <= to;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(kind, from, to);
      items_sent++;
      @(negedge clock);
   endtask

   // let every awaited result come back and the block go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_strand(input bit value);
      csr_bus.valid       <= 1'b1;
      csr_bus.plus_strand <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      board.plus_strand = value;
      strand_now = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // one transcript: exon layout in key space, codons inside, optional fault, shuffled
   task automatic run_transcript(input fault_type fault, input int exon_total);
      request_type batch[$];
      request_type held;
      bit [31:0]   start_at;
      bit [31:0]   stop_at;
      bit [31:0]   base;
      bit [31:0]   k;
      longint      off;
      longint      len;
      longint      top;
      int          n;
      int          si;
      int          ti;
      int          j;
      n = exon_total;
      if (fault == FAULT_FULL) n = MAX_EXONS_DEF + 1;
      if (fault == FAULT_OVERLAP && n < 2) n = 2;

      // relative layout, then shifted to a base that keeps every key in range
      key_first.delete();
      key_last.delete();
      off = 0;
      for (int i = 0; i < n; i++) begin
         len = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(1, 1 << 20))
                                          : longint'($urandom_range(1, 300));
         key_first.push_back(off[31:0]);
         key_last.push_back(off[31:0] + len[31:0] - 1);
         off = off + len + $urandom_range(1, 300);
      end
      top = 64'hFFFF_FFFF - longint'(key_last[n - 1]);
      case ($urandom_range(0, 9))
         0:       base = 32'd1;
         1:       base = top[31:0];
         default: base = $urandom_range(1, top[31:0] - 400);
      endcase
      for (int i = 0; i < n; i++) begin
         key_first[i] += base;
         key_last[i]  += base;
      end

      // codon keys inside the exons, start not after stop
      si = $urandom_range(0, n - 1);
      ti = $urandom_range(si, n - 1);
      start_at = key_first[si] + $urandom_range(0, key_last[si] - key_first[si]);
      stop_at  = key_first[ti] + $urandom_range(0, key_last[ti] - key_first[ti]);
      if (start_at > stop_at) begin
         k = start_at;
         start_at = stop_at;
         stop_at = k;
      end
      if (fault == FAULT_ORDER) begin
         k = start_at;
         start_at = stop_at;
         stop_at = k;
      end
      if (fault == FAULT_OUTSIDE) begin
         case ($urandom_range(0, 2))
            0: if (key_last[n - 1] != '1) stop_at = key_last[n - 1] + 1;
            1: if (key_first[0] > 1) start_at = key_first[0] - 1;
            default: if (n >= 2) stop_at = key_last[$urandom_range(0, n - 2)] + 1;
         endcase
      end

      if (fault != FAULT_NO_EXONS) begin
         for (int i = 0; i < n; i++) batch.push_back(exon_item(key_first[i], key_last[i]));
      end
      if (fault != FAULT_NO_START) add_codon_fragments(batch, KIND_START, start_at);
      if (fault != FAULT_NO_STOP) add_codon_fragments(batch, KIND_STOP, stop_at);

      case (fault)
         FAULT_UNORDERED: begin
            held.kind = KIND_EXON;
            held.pos_from = $urandom_range(2, 32'hFFFF_FFFF);
            held.pos_to = $urandom_range(0, held.pos_from - 1);
            batch.push_back(held);
         end
         FAULT_DUPLICATE: batch.push_back(batch[$urandom_range(0, n - 1)]);
         FAULT_OVERLAP: begin
            j = $urandom_range(0, n - 2);
            batch.push_back(exon_item(key_last[j] + 1, key_first[j + 1]));
         end
         FAULT_ZERO_KEY: begin
            batch.push_back(codon_item($urandom_range(0, 1) ? KIND_START : KIND_STOP, '0));
            if ($urandom_range(0, 1))
               batch.push_back(exon_item('0, strand_now ? $urandom_range(0, 20) : 0));
         end
         FAULT_NOISE: begin
            repeat ($urandom_range(2, 6)) begin
               held.kind = 2'($urandom_range(0, 3));
               held.pos_from = wild_coord();
               held.pos_to = wild_coord();
               batch.push_back(held);
            end
         end
         default: ;
      endcase

      // arrival order is random
      for (int i = batch.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         held = batch[i];
         batch[i] = batch[j];
         batch[j] = held;
      end
      foreach (batch[i]) push_request(batch[i].kind, batch[i].pos_from, batch[i].pos_to);
      push_request(KIND_FINISH, $urandom, $urandom);
   endtask

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_response(rsp_bus.cds_start, rsp_bus.cds_stop, rsp_bus.found,
                              rsp_bus.status);
         results_seen++;
      end
   end

   // receiver ready: random stalls, calm stretches, one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (!pressure_done && results_seen >= 16) begin
         pressure_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            stall_left = pick_gap();
            if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 120);
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("exon_coordinate_translator_unit test failed");
      $finish;
   end

   // stimulus sequence
   initial begin
      int        phase;
      int        items_base;
      int        roll;
      int        n;
      fault_type fault;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_EXON;
      req_bus.pos_from    = '0;
      req_bus.pos_to      = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.plus_strand = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // forward strand: full coordinate range
      push_request(KIND_EXON, 32'd1, '1);
      push_request(KIND_START, 32'd1, '0);
      push_request(KIND_STOP, '1, '1);
      push_request(KIND_FINISH, '0, '0);
      // empty transcript, then start codon only
      push_request(KIND_FINISH, '1, '1);
      push_request(KIND_START, 32'd50, 32'd60);
      push_request(KIND_FINISH, '0, '0);
      // unordered exon then duplicate: first error wins
      push_request(KIND_EXON, 32'd10, 32'd20);
      push_request(KIND_EXON, 32'd21, 32'd20);
      push_request(KIND_EXON, 32'd10, 32'd30);
      push_request(KIND_FINISH, '0, '0);
      // duplicate start key
      push_request(KIND_EXON, 32'd100, 32'd200);
      push_request(KIND_EXON, 32'd100, 32'd150);
      push_request(KIND_FINISH, '0, '0);
      // start after stop
      push_request(KIND_START, 32'd150, '0);
      push_request(KIND_STOP, 32'd120, '0);
      push_request(KIND_EXON, 32'd100, 32'd200);
      push_request(KIND_FINISH, '0, '0);
      // codons but no exons
      push_request(KIND_START, 32'd5, '0);
      push_request(KIND_STOP, 32'd6, '0);
      push_request(KIND_FINISH, '0, '0);
      // exon at key zero reads as overlap
      push_request(KIND_EXON, '0, 32'd8);
      push_request(KIND_START, 32'd3, '0);
      push_request(KIND_STOP, 32'd4, '0);
      push_request(KIND_FINISH, '0, '0);

      settle();
      write_strand(1'b0);
      // reverse strand: full range maps onto keys one through all ones
      push_request(KIND_EXON, 32'd1, '1);
      push_request(KIND_START, 32'd7, '1);
      push_request(KIND_STOP, 32'd3, 32'd1);
      push_request(KIND_FINISH, '0, '0);
      // stop codon with key zero stays unset
      push_request(KIND_STOP, '0, '0);
      push_request(KIND_EXON, 32'd100, 32'd200);
      push_request(KIND_START, '0, 32'd150);
      push_request(KIND_FINISH, '0, '0);
      // start codon in the gap between two exons
      push_request(KIND_EXON, 32'd100, 32'd200);
      push_request(KIND_EXON, 32'd300, 32'd400);
      push_request(KIND_START, '0, 32'd250);
      push_request(KIND_STOP, '0, 32'd100);
      push_request(KIND_FINISH, '0, '0);

      // random transcripts in phases, strand rewritten between phases
      items_base = items_sent;
      phase = 0;
      while (items_sent - items_base < ITEM_GOAL) begin
         settle();
         write_strand(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
         for (int t = 0; t < 8; t++) begin
            sender_calm = ($urandom_range(0, 4) == 0);
            if (phase < 2 && t < 2) begin
               run_transcript((phase + t) % 2 == 0 ? FAULT_FULL : FAULT_NONE, MAX_EXONS_DEF);
            end else begin
               roll = $urandom_range(0, 99);
               fault = (roll < 60) ? FAULT_NONE
                                   : fault_type'($urandom_range(FAULT_UNORDERED, FAULT_NOISE));
               if (fault == FAULT_FULL) fault = FAULT_NONE;
               roll = $urandom_range(0, 99);
               n = (roll < 70) ? $urandom_range(1, 4)
                 : (roll < 95) ? $urandom_range(5, 12) : $urandom_range(13, 40);
               run_transcript(fault, n);
            end
         end
         phase++;
      end

      settle();
      if (board.failures == 0) begin
         $display("exon_coordinate_translator_unit test passed");
      end else begin
         $display("exon_coordinate_translator_unit test failed");
      end
      $finish;
   end

endmodule
